// ===== sv/dfr_pkg.sv =====
`default_nettype none

package dfr_pkg;

	// default frame store depth
	localparam int MAX_FRAME_BYTES_DEF = 64;

	// field widths
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 16;
	localparam int RUN_W    = 3;
	localparam int FLEN_W   = 7;
	localparam int PERIOD_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int OUT_DATA_W = BYTE_W + 2 * COUNT_W;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_RECEIVE = 2'd0,
		OP_READ    = 2'd1,
		OP_TICK    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DELIM    = 3'd0,
		ST_REJECTED = 3'd1,
		ST_STORED   = 3'd2,
		ST_COMPLETE = 3'd3,
		ST_BUSY     = 3'd4,
		ST_BYTE     = 3'd5,
		ST_NO_FRAME = 3'd6
	} status_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELIM_VALUE  = 2'd0,
		REG_DELIM_RUN    = 2'd1,
		REG_FRAME_LENGTH = 2'd2,
		REG_TALLY_PERIOD = 2'd3
	} reg_idx_t;

	// register reset values
	localparam logic [BYTE_W-1:0]   DELIM_VALUE_RST  = 8'd255;
	localparam logic [RUN_W-1:0]    DELIM_RUN_RST    = 3'd3;
	localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST = 7'd32;
	localparam logic [PERIOD_W-1:0] TALLY_PERIOD_RST = 32'd1000;

	// control sequencer states
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_READ = 1'b1
	} fsm_t;

endpackage

`default_nettype wire

// ===== sv/dfr_ram.sv =====
`default_nettype none

module dfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/delimited_frame_receiver_top.sv =====
`default_nettype none

// channel     dir  handshake                    payload
// s_axis      in   s_axis_tvalid/s_axis_tready  tuser op, tdata rx_byte
// m_axis      out  m_axis_tvalid/m_axis_tready  tuser status, tlast last,
//                                               tdata data_byte/rejected/accepted
// cfg         in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// receive, tick and empty read words are each taken when the output register is free
// a read of a stored frame streams n words at one word per cycle while m_axis does not
// stall, paced by the frame store read port
// no input word is taken while a frame streams out
// reset clears all control state and counts; no store clearing pass is needed
// a stall on m_axis holds the output register and blocks the next input word

module delimited_frame_receiver_top
	import dfr_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
	input  wire logic [OP_W-1:0]       s_axis_tuser,   // [1:0] op
	// result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] rejected_bytes,
	                                                   // [39:24] accepted_frames
	output logic [STATUS_W-1:0]        m_axis_tuser,   // [2:0] status
	output logic                       m_axis_tlast,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// store address and cursor widths follow the frame store depth
	localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [8:0] MAX_9 = 9'(MAX_FRAME_BYTES);
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_FRAME_BYTES);

	// configuration registers
	logic [BYTE_W-1:0]   delim_value_q;
	logic [RUN_W-1:0]    delim_run_q;
	logic [FLEN_W-1:0]   frame_length_q;
	logic [PERIOD_W-1:0] tally_period_q;

	// frame state
	logic [RUN_W-1:0]    seen_q;
	logic [CW-1:0]       cursor_q;
	logic                frame_ready_q;

	// tallies
	logic [COUNT_W-1:0]  run_rej_q;
	logic [COUNT_W-1:0]  run_acc_q;
	logic [COUNT_W-1:0]  lat_rej_q;
	logic [COUNT_W-1:0]  lat_acc_q;
	logic [PERIOD_W-1:0] win_ticks_q;

	// read-out sequencer
	fsm_t                state_q, state_d;
	logic [CW-1:0]       rd_ptr_q;
	logic                valid_s1;
	logic                last_s1;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [BYTE_W-1:0]   out_data_q;
	logic                out_last_q;

	// frame store port
	logic                ram_we;
	logic                ram_re;
	logic [BYTE_W-1:0]   ram_rdata;

	// combinational controls
	logic                in_fire;
	logic                out_free;
	op_t                 op;
	logic                rd_more;
	logic                consume;
	logic                is_delim;
	logic                hunting;
	logic [8:0]          flen_9;
	logic [CW-1:0]       eff_len;
	logic [CW-1:0]       cursor_inc;
	logic                completes;
	logic [PERIOD_W-1:0] ticks_inc;
	logic                window_end;
	logic                start_read;

	assign cfg_ready = 1'b1;

	assign op        = op_t'(s_axis_tuser);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign is_delim  = (s_axis_tdata == delim_value_q);
	assign hunting   = (seen_q < delim_run_q);

	// effective frame length: zero acts as one, above the store depth clamps
	assign flen_9 = {2'b00, frame_length_q};
	always_comb begin
		if (frame_length_q == '0) begin
			eff_len = CW'(1);
		end else if (flen_9 > MAX_9) begin
			eff_len = MAX_CW;
		end else begin
			eff_len = CW'(flen_9);
		end
	end

	// cursor stays below the store depth whenever a byte is stored
	assign cursor_inc = cursor_q + CW'(1);
	assign completes  = (cursor_inc >= eff_len);

	// window ticks saturate at all ones
	assign ticks_inc  = (win_ticks_q == '1) ? win_ticks_q : win_ticks_q + PERIOD_W'(1);
	assign window_end = (ticks_inc > tally_period_q);

	assign start_read = in_fire && (op == OP_READ) && frame_ready_q && (cursor_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (start_read) begin
					state_d = FSM_READ;
				end
			end
			FSM_READ: begin
				if (consume && last_s1) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		rd_more       = 1'b0;
		consume       = 1'b0;
		ram_re        = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_axis_tready = out_free;
			end
			FSM_READ: begin
				rd_more = (rd_ptr_q != cursor_q);
				consume = valid_s1 && out_free;
				ram_re  = rd_more && (!valid_s1 || consume);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	assign ram_we = in_fire && (op == OP_RECEIVE) && !frame_ready_q && !hunting;

	dfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cursor_q[AW-1:0]),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_value_q  <= DELIM_VALUE_RST;
			delim_run_q    <= DELIM_RUN_RST;
			frame_length_q <= FRAME_LENGTH_RST;
			tally_period_q <= TALLY_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_DELIM_VALUE:  delim_value_q  <= cfg_data[BYTE_W-1:0];
				REG_DELIM_RUN:    delim_run_q    <= cfg_data[RUN_W-1:0];
				REG_FRAME_LENGTH: frame_length_q <= cfg_data[FLEN_W-1:0];
				REG_TALLY_PERIOD: tally_period_q <= cfg_data[PERIOD_W-1:0];
				default: begin
					delim_value_q <= delim_value_q;
				end
			endcase
		end
	end

	// frame state, tallies and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= FSM_IDLE;
			seen_q        <= '0;
			cursor_q      <= '0;
			frame_ready_q <= 1'b0;
			run_rej_q     <= '0;
			run_acc_q     <= '0;
			lat_rej_q     <= '0;
			lat_acc_q     <= '0;
			win_ticks_q   <= '0;
			rd_ptr_q      <= '0;
			valid_s1      <= 1'b0;
			last_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				case (op)
					OP_RECEIVE: begin
						if (!frame_ready_q) begin
							if (hunting) begin
								if (is_delim) begin
									seen_q <= seen_q + RUN_W'(1);
								end else begin
									seen_q <= '0;
									if (run_rej_q != '1) begin
										run_rej_q <= run_rej_q + COUNT_W'(1);
									end
								end
							end else begin
								cursor_q <= cursor_inc;
								if (completes) begin
									frame_ready_q <= 1'b1;
									if (run_acc_q != '1) begin
										run_acc_q <= run_acc_q + COUNT_W'(1);
									end
								end
							end
						end
					end
					OP_READ: begin
						rd_ptr_q <= '0;
					end
					OP_TICK: begin
						if (window_end) begin
							lat_rej_q   <= run_rej_q;
							lat_acc_q   <= run_acc_q;
							run_rej_q   <= '0;
							run_acc_q   <= '0;
							win_ticks_q <= '0;
						end else begin
							win_ticks_q <= ticks_inc;
						end
					end
					default: begin
						win_ticks_q <= win_ticks_q;
					end
				endcase
			end
			// read-out pipeline: store read, then output register
			if (ram_re) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
				valid_s1 <= 1'b1;
				last_s1  <= ((rd_ptr_q + CW'(1)) == cursor_q);
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			// last byte leaves the store: restart the hunt
			if (consume && last_s1) begin
				seen_q        <= '0;
				cursor_q      <= '0;
				frame_ready_q <= 1'b0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume || (in_fire && (op == OP_RECEIVE)) ||
				(in_fire && (op == OP_READ) && !start_read)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (consume) begin
			out_status_q <= ST_BYTE;
			out_data_q   <= ram_rdata;
			out_last_q   <= last_s1;
		end else if (in_fire && (op == OP_READ) && !start_read) begin
			out_status_q <= ST_NO_FRAME;
			out_data_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (in_fire && (op == OP_RECEIVE)) begin
			out_data_q <= '0;
			out_last_q <= 1'b1;
			if (frame_ready_q) begin
				out_status_q <= ST_BUSY;
			end else if (hunting) begin
				out_status_q <= is_delim ? ST_DELIM : ST_REJECTED;
			end else begin
				out_status_q <= completes ? ST_COMPLETE : ST_STORED;
			end
		end
	end

	// latched tallies cannot change while a word waits, since ticks stall behind it
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {lat_acc_q, lat_rej_q, out_data_q};

`ifndef SYNTHESIS
	a_ready_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready_q |-> (cursor_q != '0))
		else $error("frame ready with empty store");

	a_read_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_READ) |-> frame_ready_q)
		else $error("read-out without a ready frame");

	a_s1_only_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == FSM_READ))
		else $error("store read pending outside read-out");

	a_ptr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_READ) |-> (rd_ptr_q <= cursor_q))
		else $error("read pointer beyond stored bytes");

	a_readout_ends_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> (!frame_ready_q && (cursor_q == '0)))
		else $error("frame not cleared after read-out");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import dfr_pkg::*;

	// stimulus word and result word as the bench sees them
	typedef struct packed {
		op_t         op;
		logic [7:0]  rx_byte;
	} rx_word_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  data_byte;
		logic        last;
		logic [15:0] rejected;
		logic [15:0] accepted;
	} result_t;

	localparam int DRAIN_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = OP_NONE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	delimited_frame_receiver_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// generous cap: far above a full run even if every word were a full-frame read
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------
	// receiver shadow: register copies and frame state
	// ---------------------------------------------------------------
	logic [7:0]  cfg_delim  = DELIM_VALUE_RST;
	logic [2:0]  cfg_run    = DELIM_RUN_RST;
	logic [6:0]  cfg_flen   = FRAME_LENGTH_RST;
	logic [31:0] cfg_period = TALLY_PERIOD_RST;

	logic [2:0]  hunt_count  = '0;
	logic [6:0]  fill_cursor = '0;
	logic [7:0]  frame_mem [MAX_FRAME_BYTES_DEF];
	logic        frame_held  = 1'b0;
	logic [15:0] run_rej = '0;
	logic [15:0] run_acc = '0;
	logic [15:0] lat_rej = '0;
	logic [15:0] lat_acc = '0;
	logic [31:0] tick_count = '0;

	rx_word_t words_to_send [$];
	result_t  due_results [$];

	int send_idle_pct = 27;
	int recv_idle_pct = 27;

	int words_in       = 0;
	int results_seen   = 0;
	int frames_out     = 0;
	int reg_writes     = 0;
	int mismatch_count = 0;

	function automatic void expect_result(status_t st, logic [7:0] b, logic is_last);
		due_results.push_back('{status: st, data_byte: b, last: is_last,
			rejected: lat_rej, accepted: lat_acc});
	endfunction

	// effective frame length: zero acts as one, capped at the store depth
	function automatic int frame_limit();
		if (cfg_flen == 0)
			return 1;
		if (cfg_flen > MAX_FRAME_BYTES_DEF)
			return MAX_FRAME_BYTES_DEF;
		return cfg_flen;
	endfunction

	// advance the shadow by one accepted word and queue what it must produce
	task automatic receiver_step(input op_t op, input logic [7:0] rx);
		status_t st;
		int      i;
		case (op)
			OP_RECEIVE: begin
				if (frame_held) begin
					st = ST_BUSY;
				end else if (hunt_count < cfg_run) begin
					if (rx == cfg_delim) begin
						hunt_count = hunt_count + 3'd1;
						st = ST_DELIM;
					end else begin
						hunt_count = '0;
						if (run_rej != 16'hFFFF)
							run_rej = run_rej + 16'd1;
						st = ST_REJECTED;
					end
				end else begin
					if (fill_cursor < MAX_FRAME_BYTES_DEF) begin
						frame_mem[fill_cursor] = rx;
						fill_cursor = fill_cursor + 7'd1;
					end
					// completes once the cursor reaches the length in force now
					if (fill_cursor >= frame_limit()) begin
						frame_held = 1'b1;
						if (run_acc != 16'hFFFF)
							run_acc = run_acc + 16'd1;
						st = ST_COMPLETE;
					end else begin
						st = ST_STORED;
					end
				end
				expect_result(st, 8'h00, 1'b1);
			end
			OP_READ: begin
				if (!frame_held || fill_cursor == 0) begin
					expect_result(ST_NO_FRAME, 8'h00, 1'b1);
				end else begin
					// stream exactly what was stored, then restart the hunt
					for (i = 0; i < fill_cursor; i++)
						expect_result(ST_BYTE, frame_mem[i], (i + 1 == fill_cursor));
					frames_out++;
					hunt_count  = '0;
					fill_cursor = '0;
					frame_held  = 1'b0;
				end
			end
			OP_TICK: begin
				if (tick_count != 32'hFFFF_FFFF)
					tick_count = tick_count + 32'd1;
				if (tick_count > cfg_period) begin
					lat_rej    = run_rej;
					lat_acc    = run_acc;
					run_rej    = '0;
					run_acc    = '0;
					tick_count = '0;
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// input driver: random idling, else one word from the queue when the slot is free
	// ---------------------------------------------------------------
	rx_word_t next_word;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				receiver_step(op_t'(s_axis_tuser), s_axis_tdata);
				words_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = words_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= next_word.op;
					s_axis_tdata  <= next_word.rx_byte;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: random back-pressure, in-order compare
	// ---------------------------------------------------------------
	result_t want;
	result_t got;
	logic    bad;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status    = status_t'(m_axis_tuser);
				got.data_byte = m_axis_tdata[7:0];
				got.last      = m_axis_tlast;
				got.rejected  = m_axis_tdata[23:8];
				got.accepted  = m_axis_tdata[39:24];
				results_seen++;
				if (due_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result word %0d with nothing outstanding: status %0d data %02h",
							results_seen, got.status, got.data_byte);
				end else begin
					want = due_results.pop_front();
					bad = (got.status !== want.status) || (got.data_byte !== want.data_byte)
						|| (got.last !== want.last) || (got.rejected !== want.rejected)
						|| (got.accepted !== want.accepted);
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"result word %0d (exp/got): status %0d/%0d data %02h/%02h",
								" last %0b/%0b rejected %0d/%0d accepted %0d/%0d"},
								results_seen, want.status, got.status,
								want.data_byte, got.data_byte, want.last, got.last,
								want.rejected, got.rejected, want.accepted, got.accepted);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers, all called on a rising edge
	// ---------------------------------------------------------------
	function automatic void queue_word(op_t op, logic [7:0] b);
		words_to_send.push_back('{op: op, rx_byte: b});
	endfunction

	// holds cfg_valid high across back-to-back writes; caller drops it
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DELIM_VALUE:  cfg_delim  = val[7:0];
			REG_DELIM_RUN:    cfg_run    = val[2:0];
			REG_FRAME_LENGTH: cfg_flen   = val[6:0];
			REG_TALLY_PERIOD: cfg_period = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	// upper bits of the narrow registers carry junk, the block must drop it
	task automatic apply_config(input logic [7:0] dv, input logic [2:0] run,
			input logic [6:0] flen, input logic [31:0] period);
		write_reg(REG_DELIM_VALUE,  ($urandom & 32'hFFFF_FF00) | dv);
		write_reg(REG_DELIM_RUN,    ($urandom & 32'hFFFF_FFF8) | run);
		write_reg(REG_FRAME_LENGTH, ($urandom & 32'hFFFF_FF80) | flen);
		write_reg(REG_TALLY_PERIOD, period);
		cfg_valid <= 1'b0;
	endtask

	// block is idle: nothing queued or offered, nothing outstanding, ticks settled
	// checked on the falling edge so the driver's updates have landed
	task automatic wait_quiet();
		@(negedge clk);
		while (words_to_send.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly complete frames with random content, some noise and broken hunts
	task automatic queue_traffic(input int budget);
		int n, k, flen, brk;
		n = 0;
		flen = frame_limit();
		while (n < budget) begin
			if ($urandom_range(99) < 75) begin
				brk = ($urandom_range(9) == 0) ? $urandom_range(0, 7) : -1;
				for (k = 0; k < cfg_run; k++) begin
					if (k == brk)
						queue_word(OP_RECEIVE, cfg_delim ^ 8'($urandom_range(1, 255)));
					queue_word(OP_RECEIVE, cfg_delim);
				end
				for (k = 0; k < flen; k++) begin
					queue_word(OP_RECEIVE, ($urandom_range(9) == 0) ? cfg_delim
						: 8'($urandom_range(0, 255)));
					if ($urandom_range(9) == 0)
						queue_word(OP_TICK, 8'($urandom));
				end
				// byte against a full frame
				if ($urandom_range(3) == 0)
					queue_word(OP_RECEIVE, 8'($urandom));
				queue_word(OP_READ, 8'($urandom));
				n += cfg_run + flen + 1;
			end else begin
				queue_word(op_t'($urandom_range(0, 3)), ($urandom_range(3) == 0) ? cfg_delim
					: 8'($urandom));
				n++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int          ph, k;
		logic [7:0]  dv;
		logic [2:0]  run;
		logic [6:0]  flen;
		logic [31:0] period;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty read, ignored op, tick, a rejected byte
		queue_word(OP_READ, 8'h00);
		queue_word(OP_NONE, 8'hFF);
		queue_word(OP_TICK, 8'h00);
		queue_word(OP_RECEIVE, 8'h00);
		wait_quiet();

		// single delimiter of zero, short frame, latch on every tick
		apply_config(8'h00, 3'd1, 7'd3, 32'd0);
		queue_word(OP_TICK, 8'hFF);
		queue_word(OP_RECEIVE, 8'hFF);
		queue_word(OP_RECEIVE, 8'h00);
		queue_word(OP_RECEIVE, 8'hFF);
		queue_word(OP_RECEIVE, 8'h80);
		queue_word(OP_RECEIVE, 8'h7F);
		queue_word(OP_RECEIVE, 8'h01);
		queue_word(OP_READ, 8'h00);
		queue_word(OP_READ, 8'h00);
		queue_word(OP_TICK, 8'h00);
		wait_quiet();

		// no hunt at all, and a length of zero that acts as one
		apply_config(8'hAA, 3'd0, 7'd0, 32'hFFFF_FFFF);
		queue_word(OP_RECEIVE, 8'h3C);
		queue_word(OP_READ, 8'h00);
		wait_quiet();

		// longest run, oversize length; stop partway through the hunt
		apply_config(8'hAA, 3'd7, 7'd127, 32'hFFFF_FFFF);
		repeat (4) queue_word(OP_RECEIVE, 8'hAA);
		wait_quiet();

		// run cut below what was seen: data starts at once
		write_reg(REG_DELIM_RUN, 32'd2);
		cfg_valid <= 1'b0;
		queue_word(OP_RECEIVE, 8'h11);
		wait_quiet();

		// length cut to the cursor: the next byte completes a two-byte frame
		write_reg(REG_FRAME_LENGTH, 32'd1);
		cfg_valid <= 1'b0;
		queue_word(OP_RECEIVE, 8'h22);
		queue_word(OP_READ, 8'h00);
		wait_quiet();

		// a burst of rejected bytes, a tick that never latches, then latch it
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_config(8'hFF, 3'd7, 7'd8, 32'hFFFF_FFFF);
		for (k = 0; k < 16; k++)
			queue_word(OP_RECEIVE, 8'($urandom_range(0, 254)));
		queue_word(OP_TICK, 8'h00);
		wait_quiet();
		write_reg(REG_TALLY_PERIOD, 32'd0);
		cfg_valid <= 1'b0;
		queue_word(OP_TICK, 8'h00);
		queue_word(OP_READ, 8'h00);
		wait_quiet();

		// random phases; one runs with no idling on either side
		for (ph = 0; ph < 8; ph++) begin
			send_idle_pct = (ph == 3) ? 0 : 27;
			recv_idle_pct = (ph == 3) ? 0 : 27;
			case ($urandom_range(0, 3))
				0:       dv = 8'h00;
				1:       dv = 8'hFF;
				default: dv = 8'($urandom);
			endcase
			run = ($urandom_range(99) < 70) ? 3'($urandom_range(1, 3))
				: 3'($urandom_range(0, 7));
			k = $urandom_range(0, 9);
			if (k < 7)
				flen = 7'($urandom_range(1, 8));
			else if (k == 7)
				flen = 7'd0;
			else if (k == 8)
				flen = 7'd64;
			else
				flen = 7'($urandom_range(65, 127));
			k = $urandom_range(0, 19);
			if (k < 14)
				period = $urandom_range(0, 15);
			else if (k < 17)
				period = 32'hFFFF_FFFF;
			else
				period = $urandom;
			// first phase always fills the whole store behind the longest run
			if (ph == 0) begin
				run  = 3'd7;
				flen = 7'd64;
			end
			apply_config(dv, run, flen, period);
			queue_traffic(50);
			wait_quiet();
		end

		$display("run covered %0d input words and %0d result words, %0d frames read out,",
			words_in, results_seen, frames_out);
		$display("%0d register writes, %0d mismatches", reg_writes, mismatch_count);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
